@@ rtl/phm_pkg.sv @@
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types, codes and constants of the peer heartbeat monitor.
// ----------------------------------------------------------------------------
package phm_pkg;

    localparam int unsigned MaxPeersDefault = 8;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned AGE_W   = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned CFG_W   = 16;

    localparam logic [AGE_W-1:0] AGE_MAX         = '1;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0] PERIOD_RESET    = 16'd100;
    localparam logic [AGE_W-1:0] PING_TIMER_INIT = '1;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [CODE_W-1:0] t_code;

    // Input item kinds.
    localparam t_func FUNC_PKT    = 2'd0;
    localparam t_func FUNC_TICK   = 2'd1;
    localparam t_func FUNC_REMOVE = 2'd2;
    localparam t_func FUNC_NONE   = 2'd3;

    // Event codes.
    localparam t_code EV_NEW  = 2'd0;
    localparam t_code EV_LOST = 2'd1;
    localparam t_code EV_PING = 2'd2;
    localparam t_code EV_FULL = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_PERIOD  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the input item, start a new scan
        logic scan;       // walk the peer table
        logic insert;     // add the peer at the lowest free slot, report new
        logic pong_clr;   // clear the age of the matching peer
        logic remove;     // drop the matching peer, report lost
        logic emit_full;  // report table full
        logic em_next;    // skip a slot that did not time out
        logic em_read;    // fetch the key of a timed-out slot
        logic em_lost;    // report the fetched timed-out peer
        logic emit_ping;  // report a ping request
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  is_pong;
        logic  scan_done;
        logic  match;
        logic  free_found;
        logic  drop_here;
        logic  drop_none;
        logic  ping;
        logic  out_free;
    } t_stat;

endpackage

@@ rtl/phm_ctrl.sv @@
// ----------------------------------------------------------------------------
// phm_ctrl
// Sequencer of the peer heartbeat monitor: input acceptance, table scan,
// decision and ordered reporting of events.
// ----------------------------------------------------------------------------
module phm_ctrl
    import phm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_DROP_RD = 3'd3;
    localparam logic [2:0] S_DROP_EM = 3'd4;
    localparam logic [2:0] S_PING    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_stat.func)
                    FUNC_PKT: begin
                        if (i_stat.match) begin
                            o_cmd.pong_clr = i_stat.is_pong;
                            n_state        = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.insert    = i_stat.free_found;
                            o_cmd.emit_full = !i_stat.free_found;
                            n_state         = S_IDLE;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!i_stat.match) begin
                            n_state = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.remove = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    FUNC_TICK: begin
                        n_state = S_DROP_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DROP_RD: begin
                priority if (i_stat.drop_none) begin
                    n_state = i_stat.ping ? S_PING : S_IDLE;
                end else if (i_stat.drop_here) begin
                    o_cmd.em_read = 1'b1;
                    n_state       = S_DROP_EM;
                end else begin
                    o_cmd.em_next = 1'b1;
                end
            end
            S_DROP_EM: begin
                if (i_stat.out_free) begin
                    o_cmd.em_lost = 1'b1;
                    n_state       = S_DROP_RD;
                end
            end
            S_PING: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_ping = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/phm_dp.sv @@
// ----------------------------------------------------------------------------
// phm_dp
// Datapath of the peer heartbeat monitor: peer table, ages, ping timer,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module phm_dp
    import phm_pkg::*;
#(
    parameter int unsigned MAX_PEERS = MaxPeersDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ADDR_W-1:0] i_s_tdata,
    input  logic [2:0]        i_s_tuser,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [ADDR_W-1:0] o_m_tdata,
    output logic [CODE_W-1:0] o_m_tuser,
    output logic              o_m_tlast
);

    localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
    localparam logic [CNT_W-1:0] PEERS = CNT_W'(MAX_PEERS);

    // Peer table storage.
    logic [ADDR_W-1:0] key_mem [MAX_PEERS];
    logic [AGE_W-1:0]  age_mem [MAX_PEERS];

    logic [CFG_W-1:0]  r_timeout;
    logic [CFG_W-1:0]  r_period;
    logic [AGE_W-1:0]  r_ping_timer;
    logic              r_ping;

    t_func             r_func;
    logic [ADDR_W-1:0] r_addr;
    logic              r_pong;

    logic [MAX_PEERS-1:0] r_valid;
    logic [MAX_PEERS-1:0] r_drop;
    logic [CNT_W-1:0]     r_drop_cnt;
    logic [IDX_W-1:0]     r_em_idx;

    logic [CNT_W-1:0]  r_scan_idx;
    logic              r_proc_vld;
    logic [IDX_W-1:0]  r_proc_idx;
    logic              r_match;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;

    logic [ADDR_W-1:0] r_key_q;
    logic [AGE_W-1:0]  r_age_q;

    logic              r_out_valid;
    t_code             r_out_code;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_last;

    logic              scan_rd;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              proc_lookup;
    logic              proc_tick;
    logic [AGE_W-1:0]  age_inc;
    logic              age_drop;
    logic              age_we;
    logic              key_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [AGE_W-1:0]  age_wdata;
    logic [AGE_W-1:0]  ping_next;
    logic              out_free;
    logic              any_emit;

    assign out_free = !r_out_valid || i_m_tready;
    assign any_emit = i_cmd.insert | i_cmd.emit_full | i_cmd.remove |
                      i_cmd.em_lost | i_cmd.emit_ping;

    assign scan_rd = i_cmd.scan && (r_scan_idx < PEERS);
    assign rd_en   = scan_rd || i_cmd.em_read;
    assign rd_addr = i_cmd.em_read ? r_em_idx : r_scan_idx[IDX_W-1:0];

    assign proc_lookup = r_proc_vld && (r_func != FUNC_TICK);
    assign proc_tick   = r_proc_vld && (r_func == FUNC_TICK) && r_valid[r_proc_idx];
    assign age_inc     = (r_age_q == AGE_MAX) ? r_age_q : r_age_q + AGE_W'(1);
    assign age_drop    = (age_inc > r_timeout);

    assign ping_next = (r_ping_timer == AGE_MAX) ? r_ping_timer
                                                 : r_ping_timer + AGE_W'(1);

    // Single write port: ages during a tick scan, key and age on insert, age on pong.
    always_comb begin
        age_we    = 1'b0;
        key_we    = 1'b0;
        wr_addr   = r_proc_idx;
        age_wdata = '0;
        priority if (proc_tick) begin
            age_we    = 1'b1;
            age_wdata = age_drop ? '0 : age_inc;
        end else if (i_cmd.insert) begin
            age_we  = 1'b1;
            key_we  = 1'b1;
            wr_addr = r_free_idx;
        end else if (i_cmd.pong_clr) begin
            age_we  = 1'b1;
            wr_addr = r_match_idx;
        end else begin
            age_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_addr] <= r_addr;
        end
        if (age_we) begin
            age_mem[wr_addr] <= age_wdata;
        end
        if (rd_en) begin
            r_key_q <= key_mem[rd_addr];
            r_age_q <= age_mem[rd_addr];
        end
    end

    // Configuration registers and ping timer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RESET;
            r_period     <= PERIOD_RESET;
            r_ping_timer <= PING_TIMER_INIT;
            r_ping       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_PERIOD:  r_period  <= i_cfg_data;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_s_tuser[FUNC_W-1:0] == FUNC_TICK) begin
                    r_ping       <= (ping_next >= r_period);
                    r_ping_timer <= (ping_next >= r_period) ? '0 : ping_next;
                end else begin
                    r_ping <= 1'b0;
                end
            end
        end
    end

    // Input item, scan bookkeeping and valid bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_s_tuser[FUNC_W-1:0];
            r_pong <= i_s_tuser[FUNC_W];
            r_addr <= i_s_tdata;
        end
        if (scan_rd) begin
            r_proc_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (proc_lookup && r_valid[r_proc_idx] && (r_key_q == r_addr) && !r_match) begin
            r_match_idx <= r_proc_idx;
        end
        if (proc_lookup && !r_valid[r_proc_idx] && !r_free_found) begin
            r_free_idx <= r_proc_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_drop       <= '0;
            r_drop_cnt   <= '0;
            r_em_idx     <= '0;
            r_scan_idx   <= '0;
            r_proc_vld   <= 1'b0;
            r_match      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_proc_vld <= scan_rd;
            if (i_cmd.accept) begin
                r_drop       <= '0;
                r_drop_cnt   <= '0;
                r_em_idx     <= '0;
                r_scan_idx   <= '0;
                r_match      <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (scan_rd) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (proc_lookup && r_valid[r_proc_idx] && (r_key_q == r_addr)) begin
                r_match <= 1'b1;
            end
            if (proc_lookup && !r_valid[r_proc_idx]) begin
                r_free_found <= 1'b1;
            end
            if (proc_tick && age_drop) begin
                r_valid[r_proc_idx] <= 1'b0;
                r_drop[r_proc_idx]  <= 1'b1;
                r_drop_cnt          <= r_drop_cnt + CNT_W'(1);
            end
            if (i_cmd.insert) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.remove) begin
                r_valid[r_match_idx] <= 1'b0;
            end
            if (i_cmd.em_next) begin
                r_em_idx <= r_em_idx + IDX_W'(1);
            end
            if (i_cmd.em_lost) begin
                r_drop[r_em_idx] <= 1'b0;
                r_drop_cnt       <= r_drop_cnt - CNT_W'(1);
                r_em_idx         <= r_em_idx + IDX_W'(1);
            end
        end
    end

    // Result register: a new result may be loaded in the cycle the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (any_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.insert) begin
            r_out_code <= EV_NEW;
            r_out_addr <= r_addr;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_full) begin
            r_out_code <= EV_FULL;
            r_out_addr <= r_addr;
            r_out_last <= 1'b1;
        end else if (i_cmd.remove) begin
            r_out_code <= EV_LOST;
            r_out_addr <= r_addr;
            r_out_last <= 1'b1;
        end else if (i_cmd.em_lost) begin
            // Last only when no other timed-out peer and no ping follow.
            r_out_code <= EV_LOST;
            r_out_addr <= r_key_q;
            r_out_last <= (r_drop_cnt == CNT_W'(1)) && !r_ping;
        end else if (i_cmd.emit_ping) begin
            r_out_code <= EV_PING;
            r_out_addr <= '0;
            r_out_last <= 1'b1;
        end else begin
            r_out_last <= r_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_code;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_stat            = '0;
        o_stat.func       = r_func;
        o_stat.is_pong    = r_pong;
        o_stat.scan_done  = (r_scan_idx == PEERS) && !r_proc_vld;
        o_stat.match      = r_match;
        o_stat.free_found = r_free_found;
        o_stat.drop_here  = r_drop[r_em_idx];
        o_stat.drop_none  = (r_drop_cnt == '0);
        o_stat.ping       = r_ping;
        o_stat.out_free   = out_free;
    end

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.insert, i_cmd.emit_full, i_cmd.remove,
                  i_cmd.em_lost, i_cmd.emit_ping}))
        else $error("more than one result loaded in one cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_emit |-> out_free)
        else $error("result loaded over a result not yet taken");

    a_lost_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.em_lost |-> (r_drop_cnt != '0) && r_drop[r_em_idx])
        else $error("lost report without a pending timed-out slot");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop_cnt == $countones(r_drop))
        else $error("timed-out count disagrees with pending slots");

endmodule

@@ rtl/peer_heartbeat_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// peer_heartbeat_monitor_unit
// Heartbeat timeout monitor over a small table of peers.
// ----------------------------------------------------------------------------
// Input stream (s side): tdata is the peer address, tuser carries the item
// kind (packet, tick, remove) and the pong flag. Output stream (m side):
// tdata is the address of the event, tuser the event code, tlast marks the
// last event caused by one input item. Configuration writes (timeout and
// ping period) go over the cfg channel, which is always ready; they must be
// made while the monitor is idle, which the block itself does not enforce.
// Each item walks the whole peer table through one registered memory read
// port, one slot per cycle. A packet or remove result is loaded into the
// result register after the scan and the decision, and the next item is
// taken only once the sequencer is back in idle. A tick then walks the
// timed-out marks up to the last lost peer, skipping each slot that stays
// and reading and reporting each lost peer, until it finds none left; it
// then reports the ping if one is due before returning to idle.
// A one-entry result register lets the next item be accepted while the last
// result still waits; when the receiver stalls, the sequence holds before
// loading the next result. Reset empties the table, restores the register
// defaults and sets the ping timer so that the first tick pings.
// ----------------------------------------------------------------------------
module peer_heartbeat_monitor_unit
    import phm_pkg::*;
#(
    parameter int unsigned MAX_PEERS = MaxPeersDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ADDR_W-1:0] i_s_tdata,   // [31:0] peer_address
    input  logic [2:0]        i_s_tuser,   // [1:0] func, [2] is_pong
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [ADDR_W-1:0] o_m_tdata,   // [31:0] event_address
    output logic [CODE_W-1:0] o_m_tuser,   // [1:0] event_code
    output logic              o_m_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    phm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    phm_dp #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

@@ tb/peer_heartbeat_monitor_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_heartbeat_monitor_unit_checker
// Watches the input, event and configuration channels of the heartbeat
// monitor. It keeps its own copy of the peer table, ages and ping timer,
// predicts the events of every accepted input item and compares each
// accepted event with the oldest predicted one.
// ----------------------------------------------------------------------------
module peer_heartbeat_monitor_unit_checker
    import phm_pkg::*;
#(
    parameter int unsigned MAX_PEERS = MaxPeersDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              o_s_tready,
    input  logic [ADDR_W-1:0] i_s_tdata,
    input  logic [2:0]        i_s_tuser,
    input  logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  logic [ADDR_W-1:0] o_m_tdata,
    input  logic [CODE_W-1:0] o_m_tuser,
    input  logic              o_m_tlast,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    typedef struct {
        t_code             code;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_monitor_event;

    t_monitor_event    expected_events[$];
    t_monitor_event    oldest;
    int                mismatch_count = 0;

    logic [CFG_W-1:0]  cur_timeout;
    logic [CFG_W-1:0]  cur_period;
    logic              peer_live  [MAX_PEERS];
    logic [ADDR_W-1:0] peer_addr  [MAX_PEERS];
    logic [AGE_W-1:0]  peer_ticks [MAX_PEERS];
    logic [AGE_W-1:0]  ping_count;

    function automatic t_monitor_event make_event(t_code code, logic [ADDR_W-1:0] addr);
        t_monitor_event ev;
        ev.code = code;
        ev.addr = addr;
        ev.last = 1'b0;
        return ev;
    endfunction

    function automatic int find_peer_slot(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < MAX_PEERS; i++) begin
            if (peer_live[i] && peer_addr[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Updates the table copy for one input item and queues its events.
    task automatic predict_heartbeat(input t_func kind, input logic [ADDR_W-1:0] addr,
                                     input logic pong);
        t_monitor_event evs[$];
        int             slot;
        slot = find_peer_slot(addr);
        case (kind)
            FUNC_PKT: begin
                if (slot < 0) begin
                    for (int i = 0; i < MAX_PEERS && slot < 0; i++) begin
                        if (!peer_live[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        evs = {evs, make_event(EV_FULL, addr)};
                    end else begin
                        peer_live[slot]  = 1'b1;
                        peer_addr[slot]  = addr;
                        peer_ticks[slot] = '0;
                        evs = {evs, make_event(EV_NEW, addr)};
                    end
                end else if (pong) begin
                    peer_ticks[slot] = '0;
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < MAX_PEERS; i++) begin
                    if (peer_live[i]) begin
                        if (peer_ticks[i] != AGE_MAX) begin
                            peer_ticks[i] = peer_ticks[i] + 1'b1;
                        end
                        if (peer_ticks[i] > cur_timeout) begin
                            peer_live[i]  = 1'b0;
                            peer_ticks[i] = '0;
                            evs = {evs, make_event(EV_LOST, peer_addr[i])};
                        end
                    end
                end
                if (ping_count != AGE_MAX) begin
                    ping_count = ping_count + 1'b1;
                end
                if (ping_count >= cur_period) begin
                    ping_count = '0;
                    evs = {evs, make_event(EV_PING, '0)};
                end
            end
            FUNC_REMOVE: begin
                if (slot >= 0) begin
                    peer_live[slot]  = 1'b0;
                    peer_ticks[slot] = '0;
                    evs = {evs, make_event(EV_LOST, addr)};
                end
            end
            default: begin
            end
        endcase
        if (evs.size() > 0) begin
            evs[evs.size()-1].last = 1'b1;
        end
        expected_events = {expected_events, evs};
    endtask

    // Results are checked before the item accepted at the same edge is predicted,
    // since an item never produces a result in the cycle it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_timeout = TIMEOUT_RESET;
            cur_period  = PERIOD_RESET;
            ping_count  = PING_TIMER_INIT;
            for (int i = 0; i < MAX_PEERS; i++) begin
                peer_live[i]  = 1'b0;
                peer_ticks[i] = '0;
            end
            expected_events.delete();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected event: code %0d addr %h last %b",
                             $time, o_m_tuser, o_m_tdata, o_m_tlast);
                end else begin
                    oldest = expected_events.pop_front();
                    if (oldest.code !== o_m_tuser || oldest.addr !== o_m_tdata
                            || oldest.last !== o_m_tlast) begin
                        mismatch_count++;
                        $display("%0t: event mismatch: expected code %0d addr %h last %b, %s",
                                 $time, oldest.code, oldest.addr, oldest.last,
                                 $sformatf("got code %0d addr %h last %b",
                                           o_m_tuser, o_m_tdata, o_m_tlast));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TIMEOUT) begin
                    cur_timeout = i_cfg_data;
                end else begin
                    cur_period = i_cfg_data;
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_heartbeat(t_func'(i_s_tuser[1:0]), i_s_tdata, i_s_tuser[2]);
            end
        end
        o_pending <= expected_events.size();
        o_errors  <= mismatch_count;
    end

endmodule

@@ tb/peer_heartbeat_monitor_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_heartbeat_monitor_unit_tb
// Drives the heartbeat monitor with a directed sequence (new peers, pongs,
// removes, a full table, timeouts and pings) and then with random traffic
// over several timeout and ping period settings, with random gaps and
// stalls on both streams and one long output stall. A separate checker
// predicts and compares every event.
// ----------------------------------------------------------------------------
module peer_heartbeat_monitor_unit_tb;
    import phm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;
    localparam int POOL_SIZE    = 10;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 80;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [ADDR_W-1:0] i_s_tdata   = '0;
    logic [2:0]        i_s_tuser   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [ADDR_W-1:0] o_m_tdata;
    logic [CODE_W-1:0] o_m_tuser;
    logic              o_m_tlast;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = CFG_TIMEOUT;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    int                error_count;
    int                pending_events;
    int                cycle_count = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    logic              rx_hold     = 1'b0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int phase_timeout [NUM_PHASES] = '{1, 5, 65534, 20, 5, 3};
    int phase_period  [NUM_PHASES] = '{1, 3, 65535, 7, 3, 1};

    peer_heartbeat_monitor_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    peer_heartbeat_monitor_unit_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (error_count),
        .o_pending   (pending_events)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is taken. The valid
    // is left high so that the next item can follow back to back.
    task automatic send_item(input t_func kind, input logic [ADDR_W-1:0] addr,
                             input logic pong);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= {pong, kind};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Waits until every predicted event has arrived and the block has had
    // time to finish an item that causes no event.
    task automatic drain_events();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_events != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] timeout_val,
                                input logic [CFG_W-1:0] period_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= timeout_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PERIOD;
        i_cfg_data  <= period_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly addresses from a small pool so that peers are found again,
    // fill the table and time out; now and then a fresh random address.
    task automatic run_traffic(input int count);
        t_func             kind;
        logic [ADDR_W-1:0] addr;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                addr = $urandom;
            end else begin
                addr = addr_pool[$urandom_range(POOL_SIZE-1)];
            end
            if (pick < 45) begin
                kind = FUNC_PKT;
            end else if (pick < 80) begin
                kind = FUNC_TICK;
            end else if (pick < 95) begin
                kind = FUNC_REMOVE;
            end else begin
                kind = FUNC_NONE;
            end
            send_item(kind, addr, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset settings the very first tick pings.
        send_item(FUNC_TICK, '0, 1'b0);
        drain_events();
        write_config(16'd2, 16'd1);

        send_item(FUNC_PKT, 32'h0000_0000, 1'b0);
        send_item(FUNC_PKT, 32'hFFFF_FFFF, 1'b1);   // pong from an unknown peer
        send_item(FUNC_TICK, 32'h0000_0000, 1'b0);
        send_item(FUNC_PKT, 32'h0000_0000, 1'b1);   // pong refreshes the age
        send_item(FUNC_PKT, 32'h0000_0000, 1'b0);   // known peer, nothing happens
        send_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_TICK, 32'h0000_0000, 1'b0);  // the unrefreshed peer times out
        send_item(FUNC_REMOVE, 32'h1234_5678, 1'b0);
        send_item(FUNC_REMOVE, 32'h0000_0000, 1'b1);
        send_item(FUNC_NONE, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_item(FUNC_PKT, 32'hA5A5_0000 + i, i[0]);
        end
        send_item(FUNC_PKT, 32'h5A5A_5A5A, 1'b0);   // table is full
        send_item(FUNC_TICK, '0, 1'b1);
        send_item(FUNC_TICK, '0, 1'b0);
        send_item(FUNC_TICK, '0, 1'b0);             // every peer lost, then a ping
        drain_events();

        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
                addr_pool[k] = $urandom;
            end
            write_config(CFG_W'(phase_timeout[p]), CFG_W'(phase_period[p]));
            if (p < 2) begin
                tx_idle_pct <= 6;
                rx_idle_pct <= 82;
            end else if (p < 4) begin
                tx_idle_pct <= 82;
                rx_idle_pct <= 6;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            if (p == 4) begin
                // Long output stall while items keep coming, so the input backs up.
                fork
                    begin
                        repeat (30) @(posedge i_clk);
                        rx_hold <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            run_traffic(PHASE_ITEMS);
            drain_events();
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ peer_heartbeat_monitor_unit.f @@
rtl/phm_pkg.sv
rtl/phm_ctrl.sv
rtl/phm_dp.sv
rtl/peer_heartbeat_monitor_unit.sv
tb/peer_heartbeat_monitor_unit_checker.sv
tb/peer_heartbeat_monitor_unit_tb.sv
